### design/radial_alpha_falloff_defines.svh
// ----------------------------------------------------------------------------
// radial_alpha_falloff_defines.svh
// Assertion macros shared by the radial alpha falloff checker.
// ----------------------------------------------------------------------------
`ifndef RADIAL_ALPHA_FALLOFF_DEFINES_SVH
`define RADIAL_ALPHA_FALLOFF_DEFINES_SVH

// same-cycle implication
`define RAF_ASSERT_SAME(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RAF_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/raf_pkg.sv
// ----------------------------------------------------------------------------
// raf_pkg
// Constants shared by the radial alpha falloff block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package raf_pkg;
	localparam int unsigned MAX_SIZE_DEF = 1024;
	localparam int unsigned CFG_W        = 11;
	localparam int unsigned TEX_RESET    = 256;
	localparam int unsigned PIX_W        = 10;
	localparam int unsigned OFF_W        = 22;
	localparam int unsigned ALPHA_W      = 8;
	localparam int unsigned QUO_W        = 32;  // ratio fraction bits
	localparam int unsigned ROOT_W       = 16;  // Q0.16 root
	localparam int unsigned T_W          = 17;  // 0..65536
	localparam logic [T_W-1:0] ONE_Q16   = 17'h10000;
	localparam logic [ALPHA_W-1:0] ALPHA_SCALE = 8'd255;
endpackage

### design/raf_if.sv
// ----------------------------------------------------------------------------
// raf_if
// Valid/ready channels for pixel coordinates and alpha results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface raf_pix_if;
	import raf_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface raf_res_if;
	import raf_pkg::*;
	logic               valid;
	logic               ready;
	logic [OFF_W-1:0]   byte_offset;
	logic [ALPHA_W-1:0] alpha;
	modport source (output valid, output byte_offset, output alpha, input ready);
	modport sink   (input valid, input byte_offset, input alpha, output ready);
endinterface

### design/radial_alpha_falloff.sv
// ----------------------------------------------------------------------------
// radial_alpha_falloff
// Byte offset and radial alpha falloff (1 - d/dmax)^8 for one texture pixel.
// ----------------------------------------------------------------------------
//  channel   dir  payload                       transaction
//  pix       in   pixel_x[9:0], pixel_y[9:0]    valid & ready
//  res       out  byte_offset[21:0], alpha[7:0] valid & ready
//  cfg       in   cfg_wr_data[10:0]             cfg_wr_en
//
//  One transaction per cycle while the pipe advances; 3 setup stages, 32 divider
//  stages, 16 square-root stages and 4 power stages.
//  The whole pipe advances when the last stage is empty or res is taken.
//  arst_n clears all valid bits and sets texture_size to 256.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radial_alpha_falloff #(
	parameter int unsigned MAX_SIZE = raf_pkg::MAX_SIZE_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [raf_pkg::CFG_W-1:0]  cfg_wr_data,
	raf_pix_if.sink                    pix,
	raf_res_if.source                  res
);
	import raf_pkg::*;

	localparam int unsigned SW   = $clog2(MAX_SIZE + 1);
	localparam int unsigned DW   = (SW > PIX_W + 1) ? SW : PIX_W + 1;
	localparam int unsigned CMPW = (SW > CFG_W) ? SW : CFG_W;
	localparam int unsigned M2W  = 2 * SW + 1;
	localparam int unsigned D2W  = 2 * DW + 1;
	localparam int unsigned YSW  = PIX_W + SW;

	logic [CFG_W-1:0] cfg_q;
	logic             adv;
	logic [CMPW-1:0]  cfg_ext;
	logic [SW-1:0]    s_eff;
	logic [DW-1:0]    x2;
	logic [DW-1:0]    y2;
	logic [DW-1:0]    sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(TEX_RESET);
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	assign cfg_ext = CMPW'(cfg_q);
	assign s_eff   = (cfg_ext > CMPW'(MAX_SIZE)) ? SW'(MAX_SIZE) : SW'(cfg_ext);
	assign x2      = DW'({pix.pixel_x, 1'b0});
	assign y2      = DW'({pix.pixel_y, 1'b0});
	assign sd      = DW'(s_eff);

	// stage 1: deltas, row product
	logic             v_s1;
	logic [DW-1:0]    dx_s1, dy_s1;
	logic [SW-1:0]    s_s1;
	logic [YSW-1:0]   ys_s1;
	logic [PIX_W-1:0] x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= (x2 >= sd) ? x2 - sd : sd - x2;
			dy_s1 <= (y2 >= sd) ? y2 - sd : sd - y2;
			s_s1  <= s_eff;
			ys_s1 <= YSW'(pix.pixel_y * s_eff);
			x_s1  <= pix.pixel_x;
		end
	end

	// stage 2: squares, offset
	logic              v_s2;
	logic [2*DW-1:0]   dx2_s2, dy2_s2;
	logic [2*SW-1:0]   ss_s2;
	logic [OFF_W-1:0]  off_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx2_s2 <= dx_s1 * dx_s1;
			dy2_s2 <= dy_s1 * dy_s1;
			ss_s2  <= s_s1 * s_s1;
			off_s2 <= OFF_W'({(YSW + 1)'(ys_s1) + (YSW + 1)'(x_s1), 2'b00});
		end
	end

	// stage 3: D2, M2, saturation
	localparam int unsigned CW3 = (D2W > M2W) ? D2W : M2W;
	logic [D2W-1:0]   d2;
	logic [M2W-1:0]   m2;
	logic             v_s3;
	logic [M2W-1:0]   rem_s3, m2_s3;
	logic             sat_s3;
	logic [OFF_W-1:0] off_s3;

	assign d2 = D2W'(dx2_s2) + D2W'(dy2_s2);
	assign m2 = {ss_s2, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s3 <= M2W'(d2);
			m2_s3  <= m2;
			sat_s3 <= CW3'(d2) >= CW3'(m2);
			off_s3 <= off_s2;
		end
	end

	logic              rv;
	logic              rsat;
	logic [ROOT_W-1:0] rroot;
	logic [OFF_W-1:0]  roff;

	raf_ratio #(
		.M2W (M2W),
		.SBW (OFF_W)
	) u_ratio (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s3),
		.in_rem    (rem_s3),
		.in_m2     (m2_s3),
		.in_sat    (sat_s3),
		.in_side   (off_s3),
		.out_valid (rv),
		.out_sat   (rsat),
		.out_root  (rroot),
		.out_side  (roff)
	);

	// power stages
	logic [T_W-1:0]     t;
	logic [2*T_W-1:0]   t2_p, t4_p, t8_p;
	logic               v_p1, v_p2, v_p3, v_p4;
	logic [T_W-1:0]     t2_p1, t4_p2, t8_p3;
	logic [OFF_W-1:0]   off_p1, off_p2, off_p3, off_p4;
	logic [ALPHA_W-1:0] alpha_p4;
	logic [T_W+ALPHA_W-1:0] a_p;

	assign t    = rsat ? '0 : ONE_Q16 - T_W'(rroot);
	assign t2_p = t * t;
	assign t4_p = t2_p1 * t2_p1;
	assign t8_p = t4_p2 * t4_p2;
	assign a_p  = t8_p3 * ALPHA_SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			v_p4 <= 1'b0;
		end else if (adv) begin
			v_p1 <= rv;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_p4 <= v_p3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t2_p1    <= T_W'(t2_p >> 16);
			t4_p2    <= T_W'(t4_p >> 16);
			t8_p3    <= T_W'(t8_p >> 16);
			alpha_p4 <= ALPHA_W'(a_p >> 16);
			off_p1   <= roff;
			off_p2   <= off_p1;
			off_p3   <= off_p2;
			off_p4   <= off_p3;
		end
	end

	assign adv             = !v_p4 || res.ready;
	assign pix.ready       = adv;
	assign res.valid       = v_p4;
	assign res.byte_offset = off_p4;
	assign res.alpha       = alpha_p4;
endmodule

### design/raf_ratio.sv
// ----------------------------------------------------------------------------
// raf_ratio
// Pipelined restoring divider (D2/M2, 32 fraction bits) followed by a
// pipelined integer square root; one bit per stage, 48 stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module raf_ratio #(
	parameter int unsigned M2W = 23,
	parameter int unsigned SBW = 22
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [M2W-1:0]              in_rem,
	input  logic [M2W-1:0]              in_m2,
	input  logic                        in_sat,
	input  logic [SBW-1:0]              in_side,
	output logic                        out_valid,
	output logic                        out_sat,
	output logic [raf_pkg::ROOT_W-1:0]  out_root,
	output logic [SBW-1:0]              out_side
);
	import raf_pkg::*;

	localparam int unsigned RRW = ROOT_W + 2;

	logic             dv_s   [0:QUO_W];
	logic [M2W-1:0]   drem_s [0:QUO_W];
	logic [M2W-1:0]   dm2_s  [0:QUO_W];
	logic [QUO_W-1:0] dquo_s [0:QUO_W];
	logic             dsat_s [0:QUO_W];
	logic [SBW-1:0]   dside_s[0:QUO_W];

	assign dv_s[0]    = in_valid;
	assign drem_s[0]  = in_rem;
	assign dm2_s[0]   = in_m2;
	assign dquo_s[0]  = '0;
	assign dsat_s[0]  = in_sat;
	assign dside_s[0] = in_side;

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic [M2W:0] sh;
		logic [M2W:0] df;
		logic         ge;
		assign sh = {drem_s[k], 1'b0};
		assign df = sh - {1'b0, dm2_s[k]};
		assign ge = sh >= {1'b0, dm2_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_s[k+1] <= dv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				drem_s[k+1]  <= ge ? df[M2W-1:0] : sh[M2W-1:0];
				dquo_s[k+1]  <= {dquo_s[k][QUO_W-2:0], ge};
				dm2_s[k+1]   <= dm2_s[k];
				dsat_s[k+1]  <= dsat_s[k];
				dside_s[k+1] <= dside_s[k];
			end
		end
	end

	logic              rv_s   [0:ROOT_W];
	logic [RRW-1:0]    rrem_s [0:ROOT_W];
	logic [ROOT_W-1:0] rroot_s[0:ROOT_W];
	logic [QUO_W-1:0]  rrad_s [0:ROOT_W];
	logic              rsat_s [0:ROOT_W];
	logic [SBW-1:0]    rside_s[0:ROOT_W];

	assign rv_s[0]    = dv_s[QUO_W];
	assign rrem_s[0]  = '0;
	assign rroot_s[0] = '0;
	assign rrad_s[0]  = dquo_s[QUO_W];
	assign rsat_s[0]  = dsat_s[QUO_W];
	assign rside_s[0] = dside_s[QUO_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		logic [RRW+1:0] cur;
		logic [RRW+1:0] trial;
		logic [RRW+1:0] df;
		logic           ge;
		assign cur   = {rrem_s[j], rrad_s[j][QUO_W-1 -: 2]};
		assign trial = (RRW+2)'({rroot_s[j], 2'b01});
		assign df    = cur - trial;
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[j+1] <= 1'b0;
			end else if (en) begin
				rv_s[j+1] <= rv_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rrem_s[j+1]  <= ge ? df[RRW-1:0] : cur[RRW-1:0];
				rroot_s[j+1] <= {rroot_s[j][ROOT_W-2:0], ge};
				rrad_s[j+1]  <= {rrad_s[j][QUO_W-3:0], 2'b00};
				rsat_s[j+1]  <= rsat_s[j];
				rside_s[j+1] <= rside_s[j];
			end
		end
	end

	assign out_valid = rv_s[ROOT_W];
	assign out_sat   = rsat_s[ROOT_W];
	assign out_root  = rroot_s[ROOT_W];
	assign out_side  = rside_s[ROOT_W];
endmodule

### design/raf_checker.sv
// ----------------------------------------------------------------------------
// raf_checker
// Port-level assertions for the radial alpha falloff block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radial_alpha_falloff_defines.svh"

module raf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_valid,
	input logic        pix_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [21:0] res_byte_offset,
	input logic [7:0]  res_alpha
);
	`RAF_ASSERT_SAME(a_ready_tracks, clk, arst_n, 1'b1, pix_ready == (!res_valid || res_ready), "input ready does not follow output stall")
	`RAF_ASSERT_SAME(a_offset_aligned, clk, arst_n, res_valid, res_byte_offset[1:0] == 2'b00, "byte offset not RGBA aligned")
	`RAF_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_byte_offset) && $stable(res_alpha), "stalled result changed")
endmodule

bind radial_alpha_falloff raf_checker u_raf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pix_valid       (pix.valid),
	.pix_ready       (pix.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_byte_offset (res.byte_offset),
	.res_alpha       (res.alpha)
);
